/* src/ips_patch_stream_parser_macros.svh */
// Assertion macros shared by the IPS patch parser modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef IPS_PATCH_STREAM_PARSER_MACROS_SVH
`define IPS_PATCH_STREAM_PARSER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define IPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next clock cycle.
`define IPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ips_pkg.sv */
// Types and constants of the IPS patch stream parser.
// Used by ips_core, ips_out_buf and ips_patch_stream_parser.
package ips_pkg;

    localparam logic [23:0] EOF_ADDR  = 24'h454F46;
    localparam logic [24:0] MAX_PATCH = 25'h1000000;
    localparam logic [24:0] MIN_PATCH = 25'h0000009;

    localparam logic [1:0] CFG_PATCH_LENGTH = 2'd0;
    localparam logic [1:0] CFG_DEST_SIZE    = 2'd1;
    localparam logic [1:0] CFG_SOURCE_SIZE  = 2'd2;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER    = 3'd1;
    localparam logic [2:0] ST_DEST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_TRUNCATED     = 3'd3;
    localparam logic [2:0] ST_BAD_SIZES     = 3'd4;

    typedef enum logic [3:0] {
        PH_HDR0  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_HDR2  = 4'd2,
        PH_HDR3  = 4'd3,
        PH_HDR4  = 4'd4,
        PH_ADDR0 = 4'd5,
        PH_ADDR1 = 4'd6,
        PH_ADDR2 = 4'd7,
        PH_SIZE0 = 4'd8,
        PH_SIZE1 = 4'd9,
        PH_DATA  = 4'd10,
        PH_CNT0  = 4'd11,
        PH_CNT1  = 4'd12,
        PH_VAL   = 4'd13
    } phase_t;

    typedef struct packed {
        logic [24:0] patch_length;
        logic [24:0] dest_size;
        logic [24:0] source_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] address;
        logic [15:0] count;
        logic [7:0]  value;
        logic [2:0]  status;
        logic        final_res;
    } res_t;

    function automatic logic [7:0] hdr_char(input phase_t ph);
        logic [7:0] c;
        case (ph)
            PH_HDR0: c = 8'h50;
            PH_HDR1: c = 8'h41;
            PH_HDR2: c = 8'h54;
            PH_HDR3: c = 8'h43;
            PH_HDR4: c = 8'h48;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic res_t status_res(input logic [2:0] st);
        res_t r;
        r.kind      = KIND_STATUS;
        r.address   = 24'd0;
        r.count     = 16'd0;
        r.value     = 8'd0;
        r.status    = st;
        r.final_res = 1'b1;
        return r;
    endfunction

endpackage

/* src/ips_core.sv */
// Parse state and combinational step logic of the IPS patch parser.
// Depends on ips_pkg and ips_patch_stream_parser_macros.svh.
`include "ips_patch_stream_parser_macros.svh"

module ips_core
    import ips_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] patch_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [24:0] bc_reg, bc_next;
    logic [24:0] addr_reg, addr_next;
    logic [15:0] len_reg, len_next;
    logic        stopped_reg, stopped_next;

    logic        last;
    logic        fin;
    logic [24:0] lim;
    logic [24:0] avail;
    logic [24:0] addr_inc;
    logic [15:0] len_dec;
    logic [15:0] len_low;
    logic [23:0] addr_full;
    logic        sizes_bad;
    logic [2:0]  cut_cur;

    always_comb
    begin
        last      = ({1'b0, bc_reg} + 26'd1) >= {1'b0, cfg.patch_length};
        lim       = (cfg.dest_size < MAX_PATCH) ? cfg.dest_size : MAX_PATCH;
        avail     = (addr_reg >= lim) ? 25'd0 : (lim - addr_reg);
        addr_inc  = addr_reg + 25'd1;
        len_dec   = len_reg - 16'd1;
        len_low   = len_reg | {8'd0, patch_byte};
        addr_full = {addr_reg[23:8], patch_byte};
        cut_cur   = (addr_reg >= lim) ? ST_DEST_OVERFLOW : ST_TRUNCATED;
        sizes_bad = (cfg.dest_size == 25'd0) || (cfg.source_size == 25'd0) ||
                    (cfg.dest_size < cfg.source_size) ||
                    (cfg.patch_length < MIN_PATCH) || (cfg.patch_length > MAX_PATCH);

        phase_next   = phase_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        res_valid    = 1'b0;
        res          = status_res(ST_OK);
        fin          = 1'b0;

        if (!stopped_reg)
        begin
            case (phase_reg)
                PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4:
                begin
                    if ((phase_reg == PH_HDR0) && sizes_bad)
                    begin
                        res = status_res(ST_BAD_SIZES);
                        res_valid = 1'b1;
                        fin = 1'b1;
                    end
                    else if (patch_byte != hdr_char(phase_reg))
                    begin
                        res = status_res(ST_BAD_HEADER);
                        res_valid = 1'b1;
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_t'(phase_reg + 4'd1);
                    end
                end
                PH_ADDR0, PH_ADDR1:
                begin
                    if (phase_reg == PH_ADDR0)
                        addr_next = {1'b0, patch_byte, 16'd0};
                    else
                        addr_next = addr_reg | {9'd0, patch_byte, 8'd0};
                    phase_next = phase_t'(phase_reg + 4'd1);
                    if (last)
                    begin
                        res_valid = 1'b1;
                        fin = 1'b1;
                    end
                end
                PH_ADDR2:
                begin
                    addr_next  = addr_reg | {17'd0, patch_byte};
                    phase_next = PH_SIZE0;
                    if (last || (addr_full == EOF_ADDR && !addr_reg[24]))
                    begin
                        res_valid = 1'b1;
                        fin = 1'b1;
                    end
                end
                PH_SIZE0, PH_CNT0:
                begin
                    len_next   = {patch_byte, 8'd0};
                    phase_next = phase_t'(phase_reg + 4'd1);
                    if (last)
                    begin
                        res_valid = 1'b1;
                        fin = 1'b1;
                    end
                end
                PH_SIZE1, PH_CNT1:
                begin
                    len_next = len_low;
                    if (phase_reg == PH_SIZE1)
                        phase_next = (len_low == 16'd0) ? PH_CNT0 : PH_DATA;
                    else
                        phase_next = PH_VAL;
                    if (last)
                    begin
                        res = status_res((len_low == 16'd0) ? ST_OK : cut_cur);
                        res_valid = 1'b1;
                        fin = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (addr_reg >= lim)
                    begin
                        res = status_res(ST_DEST_OVERFLOW);
                        fin = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_inc;
                        len_next  = len_dec;
                        if (len_dec == 16'd0)
                            phase_next = PH_ADDR0;
                        res.kind      = KIND_WRITE;
                        res.address   = addr_reg[23:0];
                        res.count     = 16'd1;
                        res.value     = patch_byte;
                        res.final_res = last;
                        if (last)
                        begin
                            fin = 1'b1;
                            if (len_dec != 16'd0)
                                res.status = (addr_inc >= lim) ? ST_DEST_OVERFLOW
                                                               : ST_TRUNCATED;
                        end
                    end
                end
                PH_VAL:
                begin
                    phase_next = PH_ADDR0;
                    if (len_reg == 16'd0)
                    begin
                        if (last)
                        begin
                            res_valid = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    else if (last)
                    begin
                        res = status_res(cut_cur);
                        res_valid = 1'b1;
                        fin = 1'b1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        if ({9'd0, len_reg} <= avail)
                        begin
                            res.kind      = KIND_FILL;
                            res.address   = addr_reg[23:0];
                            res.count     = len_reg;
                            res.value     = patch_byte;
                            res.final_res = 1'b0;
                            addr_next     = addr_reg + {9'd0, len_reg};
                        end
                        else if (avail == 25'd0)
                        begin
                            res = status_res(ST_DEST_OVERFLOW);
                            fin = 1'b1;
                        end
                        else
                        begin
                            res.kind    = KIND_FILL;
                            res.address = addr_reg[23:0];
                            res.count   = avail[15:0];
                            res.value   = patch_byte;
                            res.status  = ST_DEST_OVERFLOW;
                            fin = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end

        if (last)
        begin
            phase_next   = PH_HDR0;
            bc_next      = 25'd0;
            addr_next    = 25'd0;
            len_next     = 16'd0;
            stopped_next = 1'b0;
        end
        else
        begin
            bc_next      = bc_reg + 25'd1;
            stopped_next = stopped_reg | fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            bc_reg      <= 25'd0;
            addr_reg    <= 25'd0;
            len_reg     <= 16'd0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            addr_reg    <= addr_next;
            len_reg     <= len_next;
            stopped_reg <= stopped_next;
        end
    end

    `IPS_ASSERT_NEXT(a_stop_after_final, accept && res_valid && res.final_res && !last, stopped_reg, "parse did not stop after a final result")
    `IPS_ASSERT_NEXT(a_rearm_on_last, accept && last, (phase_reg == PH_HDR0) && !stopped_reg && (bc_reg == 25'd0), "parser did not rearm at patch end")
    `IPS_ASSERT(a_no_result_stopped, !(stopped_reg && res_valid), "result produced while stopped")

endmodule

/* src/ips_out_buf.sv */
// Two-entry result buffer (output register plus skid) of the IPS patch parser.
// Depends on ips_pkg and ips_patch_stream_parser_macros.svh.
`include "ips_patch_stream_parser_macros.svh"

module ips_out_buf
    import ips_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_data
);

    logic [1:0] cnt_reg, cnt_next;
    res_t       head_reg, head_next;
    res_t       skid_reg, skid_next;
    logic       pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign out_data  = head_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next = push_data;
                    cnt_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                    head_next = push_data;
                else if (push)
                begin
                    skid_next = push_data;
                    cnt_next  = 2'd2;
                end
                else if (pop)
                    cnt_next = 2'd0;
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = skid_reg;
                    cnt_next  = 2'd1;
                end
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    `IPS_ASSERT(a_cnt_range, cnt_reg != 2'd3, "buffer count out of range")
    `IPS_ASSERT(a_no_push_full, !(push && full), "push into full buffer")
    `IPS_ASSERT_NEXT(a_held_on_stall, out_valid && out_stall, $stable(out_data), "head changed under stall")

endmodule

/* src/ips_patch_stream_parser.sv */
// IPS patch stream parser: one patch byte per transaction in, one optional command out.
// Results: a result enters the output buffer when its byte is accepted and leaves from the head register.
// Throughput: one byte per cycle while in_stall is low; a two-entry output buffer keeps input open under a stall.
// Input stalls only while both output entries hold results.
// Reset: rst_n asynchronous, clears parse state, configuration and buffer count.
// Depends on ips_pkg, ips_core and ips_out_buf.
module ips_patch_stream_parser
    import ips_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  patch_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [23:0] address,
    output logic [15:0] count,
    output logic [7:0]  value,
    output logic [2:0]  status,
    output logic        final_res
);

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic res_valid;
    res_t res;
    res_t out_data;
    logic full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATCH_LENGTH: cfg_next.patch_length = cfg_data;
                CFG_DEST_SIZE:    cfg_next.dest_size    = cfg_data;
                CFG_SOURCE_SIZE:  cfg_next.source_size  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    ips_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .patch_byte (patch_byte),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    ips_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind      = out_data.kind;
    assign address   = out_data.address;
    assign count     = out_data.count;
    assign value     = out_data.value;
    assign status    = out_data.status;
    assign final_res = out_data.final_res;

endmodule
